FILE: sv/psch_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package psch_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_ARRIVAL  = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  typedef logic [QA_W-1:0] qaddr_t;
  typedef logic [QC_W-1:0] qcnt_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [7:0]  prio;
    logic [31:0] total;
    logic [31:0] remaining;
  } entry_t;

  typedef struct packed {
    logic   en;
    qaddr_t addr;
    entry_t data;
  } qwr_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SLAST = 6'b000100,
    S_SETUP = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

FILE: sv/psch_queue.sv
// Ready queue storage: one write port, one read port with registered read data.
module psch_queue (
  input  logic            clk,
  input  psch_pkg::qwr_t  wr,
  input  logic            rd_en,
  input  psch_pkg::qaddr_t rd_addr,
  output psch_pkg::entry_t rd_data
);
  import psch_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/psch_minscan.sv
// Priority compare unit: tracks the most urgent entry over a scan.
module psch_minscan (
  input  logic             clk,
  input  logic             take,
  input  logic             first,
  input  psch_pkg::qaddr_t idx,
  input  psch_pkg::entry_t entry,
  output psch_pkg::qaddr_t best_idx,
  output psch_pkg::entry_t best_entry
);
  import psch_pkg::*;

  qaddr_t best_idx_r;
  entry_t best_entry_r;
  logic   wins;

  // later index wins among equal priorities
  assign wins = first || (entry.prio <= best_entry_r.prio);

  always_ff @(posedge clk) begin
    if (take && wins) begin
      best_idx_r   <= idx;
      best_entry_r <= entry;
    end
  end

  assign best_idx   = best_idx_r;
  assign best_entry = best_entry_r;

endmodule

FILE: sv/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level: running task, ready queue and sequencer.
// Arrival: registered result strobe in the cycle after acceptance; busy stays low.
// Completion, empty queue: registered result strobe in the cycle after acceptance.
// Completion, n queued: one scan pass and one shift pass over the single queue read port,
// then the result strobe; busy is high meanwhile.
// Synchronous active-low reset: nothing running, queue empty; results cannot be stalled.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_now_time,
  input  logic [7:0]  in_new_id,
  input  logic [31:0] in_new_arrival,
  input  logic [7:0]  in_new_priority,
  input  logic [31:0] in_new_burst,
  output logic        out_strobe,
  output logic        out_run_valid,
  output logic [7:0]  out_run_id,
  output logic [31:0] out_run_arrival,
  output logic [7:0]  out_run_priority,
  output logic [31:0] out_run_total,
  output logic [31:0] out_run_start,
  output logic [31:0] out_run_end,
  output logic [31:0] out_run_remaining,
  output logic        out_queue_overflow
);
  import psch_pkg::*;

  state_t      state_r, state_nxt;
  qcnt_t       count_r, count_nxt;
  qcnt_t       idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  qaddr_t      vidx_r, vidx_nxt;
  logic [31:0] now_r, now_nxt;
  logic        strobe_r, strobe_nxt;
  logic        ovf_r, ovf_nxt;

  logic        run_valid_r, run_valid_nxt;
  logic [7:0]  run_id_r, run_id_nxt;
  logic [31:0] run_arrival_r, run_arrival_nxt;
  logic [7:0]  run_priority_r, run_priority_nxt;
  logic [31:0] run_total_r, run_total_nxt;
  logic [31:0] run_start_r, run_start_nxt;
  logic [31:0] run_end_r, run_end_nxt;
  logic [31:0] run_rem_r, run_rem_nxt;

  logic   accept;
  qcnt_t  last;
  qwr_t   qwr;
  logic   rd_en;
  entry_t rd_data;
  logic   scan_take;
  qaddr_t best_idx;
  entry_t best_entry;
  entry_t new_entry;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign last   = count_r - qcnt_t'(1);

  assign new_entry.id        = in_new_id;
  assign new_entry.arrival   = in_new_arrival;
  assign new_entry.prio      = in_new_priority;
  assign new_entry.total     = in_new_burst;
  assign new_entry.remaining = in_new_burst;

  assign scan_take = vld_r && ((state_r == S_SCAN) || (state_r == S_SLAST));

  psch_queue u_queue (
    .clk     (clk),
    .wr      (qwr),
    .rd_en   (rd_en),
    .rd_addr (idx_r[QA_W-1:0]),
    .rd_data (rd_data)
  );

  psch_minscan u_minscan (
    .clk        (clk),
    .take       (scan_take),
    .first      (vidx_r == '0),
    .idx        (vidx_r),
    .entry      (rd_data),
    .best_idx   (best_idx),
    .best_entry (best_entry)
  );

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    idx_nxt          = idx_r;
    now_nxt          = now_r;
    strobe_nxt       = 1'b0;
    ovf_nxt          = ovf_r;
    run_valid_nxt    = run_valid_r;
    run_id_nxt       = run_id_r;
    run_arrival_nxt  = run_arrival_r;
    run_priority_nxt = run_priority_r;
    run_total_nxt    = run_total_r;
    run_start_nxt    = run_start_r;
    run_end_nxt      = run_end_r;
    run_rem_nxt      = run_rem_r;
    rd_en            = 1'b0;
    qwr.en           = 1'b0;
    qwr.addr         = count_r[QA_W-1:0];
    qwr.data         = new_entry;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_ARRIVAL) begin
            strobe_nxt = 1'b1;
            ovf_nxt    = 1'b0;
            if (!run_valid_r) begin
              run_valid_nxt    = 1'b1;
              run_id_nxt       = in_new_id;
              run_arrival_nxt  = in_new_arrival;
              run_priority_nxt = in_new_priority;
              run_total_nxt    = in_new_burst;
              run_start_nxt    = in_now_time;
              run_end_nxt      = in_now_time + in_new_burst;
              run_rem_nxt      = in_new_burst;
            end else if (count_r >= qcnt_t'(QUEUE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else if (in_new_priority >= run_priority_r) begin
              qwr.en    = 1'b1;
              count_nxt = count_r + qcnt_t'(1);
            end else begin
              // preempt: requeue the running task with what is left of it
              qwr.en                 = 1'b1;
              qwr.data.id            = run_id_r;
              qwr.data.arrival       = run_arrival_r;
              qwr.data.prio          = run_priority_r;
              qwr.data.total         = run_total_r;
              qwr.data.remaining     = run_end_r - in_now_time;
              count_nxt              = count_r + qcnt_t'(1);
              run_valid_nxt          = 1'b1;
              run_id_nxt             = in_new_id;
              run_arrival_nxt        = in_new_arrival;
              run_priority_nxt       = in_new_priority;
              run_total_nxt          = in_new_burst;
              run_start_nxt          = in_now_time;
              run_end_nxt            = in_now_time + in_new_burst;
              run_rem_nxt            = in_new_burst;
            end
          end else if (count_r == '0) begin
            strobe_nxt       = 1'b1;
            ovf_nxt          = 1'b0;
            run_valid_nxt    = 1'b0;
            run_id_nxt       = '0;
            run_arrival_nxt  = '0;
            run_priority_nxt = '0;
            run_total_nxt    = '0;
            run_start_nxt    = '0;
            run_end_nxt      = '0;
            run_rem_nxt      = '0;
          end else begin
            now_nxt   = in_now_time;
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + qcnt_t'(1);
        if (idx_r == last) begin
          state_nxt = S_SLAST;
        end
      end
      S_SLAST: begin
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        idx_nxt   = qcnt_t'(best_idx) + qcnt_t'(1);
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (idx_r < count_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + qcnt_t'(1);
        end
        if (vld_r) begin
          qwr.en   = 1'b1;
          qwr.addr = vidx_r - qaddr_t'(1);
          qwr.data = rd_data;
        end
        if (!(idx_r < count_r) && !vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        count_nxt        = count_r - qcnt_t'(1);
        run_valid_nxt    = 1'b1;
        run_id_nxt       = best_entry.id;
        run_arrival_nxt  = best_entry.arrival;
        run_priority_nxt = best_entry.prio;
        run_total_nxt    = best_entry.total;
        run_start_nxt    = now_r;
        run_end_nxt      = now_r + best_entry.remaining;
        run_rem_nxt      = best_entry.remaining;
        ovf_nxt          = 1'b0;
        strobe_nxt       = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign vld_nxt  = rd_en;
  assign vidx_nxt = idx_r[QA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      vld_r          <= 1'b0;
      strobe_r       <= 1'b0;
      ovf_r          <= 1'b0;
      run_valid_r    <= 1'b0;
      run_id_r       <= '0;
      run_arrival_r  <= '0;
      run_priority_r <= '0;
      run_total_r    <= '0;
      run_start_r    <= '0;
      run_end_r      <= '0;
      run_rem_r      <= '0;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      vld_r          <= vld_nxt;
      strobe_r       <= strobe_nxt;
      ovf_r          <= ovf_nxt;
      run_valid_r    <= run_valid_nxt;
      run_id_r       <= run_id_nxt;
      run_arrival_r  <= run_arrival_nxt;
      run_priority_r <= run_priority_nxt;
      run_total_r    <= run_total_nxt;
      run_start_r    <= run_start_nxt;
      run_end_r      <= run_end_nxt;
      run_rem_r      <= run_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    vidx_r <= vidx_nxt;
    now_r  <= now_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_run_valid      = run_valid_r;
  assign out_run_id         = run_id_r;
  assign out_run_arrival    = run_arrival_r;
  assign out_run_priority   = run_priority_r;
  assign out_run_total      = run_total_r;
  assign out_run_start      = run_start_r;
  assign out_run_end        = run_end_r;
  assign out_run_remaining  = run_rem_r;
  assign out_queue_overflow = ovf_r;

endmodule

FILE: dv/preemptive_priority_scheduler_tb.sv
// Testbench for the preemptive priority scheduler: event stimulus and self-checking of each run result.
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psch_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 134;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [7:0]  prio;
    logic [31:0] total;
    logic [31:0] remaining;
  } ready_task_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [7:0]  prio;
    logic [31:0] total;
    logic [31:0] start_at;
    logic [31:0] end_at;
    logic [31:0] remaining;
    logic        overflow;
  } run_info_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] now;
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [7:0]  prio;
    logic [31:0] burst;
  } sched_event_t;

  class sched_scoreboard;
    bit          cur_valid;
    ready_task_t cur;
    logic [31:0] cur_start;
    logic [31:0] cur_end;
    ready_task_t ready[$];
    run_info_t   expected_runs[$];
    int errors, results, arrivals, completions, overflows, null_runs, deepest;

    function void launch(ready_task_t t, logic [31:0] now);
      cur_valid = 1'b1;
      cur = t;
      cur_start = now;
      cur_end = now + t.remaining;
    endfunction

    function run_info_t running_view(bit ovf);
      run_info_t r;
      r.valid = cur_valid;
      r.id = cur.id;
      r.arrival = cur.arrival;
      r.prio = cur.prio;
      r.total = cur.total;
      r.start_at = cur_start;
      r.end_at = cur_end;
      r.remaining = cur_end - cur_start;
      r.overflow = ovf;
      return r;
    endfunction

    function void note_event(sched_event_t ev);
      ready_task_t nt;
      ready_task_t old;
      run_info_t   blank;
      int i;
      int pick;
      bit ovf;
      ovf = 1'b0;
      blank = '0;
      nt = '{ev.id, ev.arrival, ev.prio, ev.burst, ev.burst};
      if (ev.mode == MODE_ARRIVAL) begin
        arrivals++;
        if (!cur_valid) begin
          launch(nt, ev.now);
        end else if (ready.size() >= QUEUE_DEPTH) begin
          ovf = 1'b1;
        end else if (ev.prio >= cur.prio) begin
          ready.push_back(nt);
        end else begin
          old = cur;
          old.remaining = cur_end - ev.now;
          ready.push_back(old);
          launch(nt, ev.now);
        end
        expected_runs.push_back(running_view(ovf));
      end else if (ready.size() == 0) begin
        completions++;
        cur_valid = 1'b0;
        cur = '0;
        cur_start = '0;
        cur_end = '0;
        expected_runs.push_back(blank);
      end else begin
        completions++;
        pick = 0;
        for (i = 1; i < ready.size(); i++) begin
          if (ready[i].prio <= ready[pick].prio) pick = i;
        end
        launch(ready[pick], ev.now);
        ready.delete(pick);
        expected_runs.push_back(running_view(1'b0));
      end
      if (ready.size() > deepest) deepest = ready.size();
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_run(run_info_t got);
      run_info_t exp_r;
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %p", $time, got);
        return;
      end
      exp_r = expected_runs.pop_front();
      results++;
      if (exp_r.overflow) overflows++;
      if (!exp_r.valid) null_runs++;
      compare("run_valid", exp_r.valid, got.valid);
      compare("run_id", exp_r.id, got.id);
      compare("run_arrival", exp_r.arrival, got.arrival);
      compare("run_priority", exp_r.prio, got.prio);
      compare("run_total", exp_r.total, got.total);
      compare("run_start", exp_r.start_at, got.start_at);
      compare("run_end", exp_r.end_at, got.end_at);
      compare("run_remaining", exp_r.remaining, got.remaining);
      compare("queue_overflow", exp_r.overflow, got.overflow);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [31:0] in_now_time;
  logic [7:0]  in_new_id;
  logic [31:0] in_new_arrival;
  logic [7:0]  in_new_priority;
  logic [31:0] in_new_burst;
  logic        out_strobe;
  logic        out_run_valid;
  logic [7:0]  out_run_id;
  logic [31:0] out_run_arrival;
  logic [7:0]  out_run_priority;
  logic [31:0] out_run_total;
  logic [31:0] out_run_start;
  logic [31:0] out_run_end;
  logic [31:0] out_run_remaining;
  logic        out_queue_overflow;

  sched_scoreboard sb = new;
  int stall_cycles = 0;
  logic [31:0] clock_now = 0;

  preemptive_priority_scheduler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_now_time        (in_now_time),
    .in_new_id          (in_new_id),
    .in_new_arrival     (in_new_arrival),
    .in_new_priority    (in_new_priority),
    .in_new_burst       (in_new_burst),
    .out_strobe         (out_strobe),
    .out_run_valid      (out_run_valid),
    .out_run_id         (out_run_id),
    .out_run_arrival    (out_run_arrival),
    .out_run_priority   (out_run_priority),
    .out_run_total      (out_run_total),
    .out_run_start      (out_run_start),
    .out_run_end        (out_run_end),
    .out_run_remaining  (out_run_remaining),
    .out_queue_overflow (out_queue_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      stall_cycles++;
      if (out_strobe) begin
        stall_cycles = 0;
        sb.check_run('{out_run_valid, out_run_id, out_run_arrival, out_run_priority,
                       out_run_total, out_run_start, out_run_end, out_run_remaining,
                       out_queue_overflow});
      end
      if (start && !busy) begin
        stall_cycles = 0;
        sb.note_event('{in_mode, in_now_time, in_new_id, in_new_arrival,
                        in_new_priority, in_new_burst});
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[preemptive_priority_scheduler] ERROR");
        $finish;
      end
    end
  end

  task automatic issue(input sched_event_t ev, input int idle_pct);
    in_mode <= ev.mode;
    in_now_time <= ev.now;
    in_new_id <= ev.id;
    in_new_arrival <= ev.arrival;
    in_new_priority <= ev.prio;
    in_new_burst <= ev.burst;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic sched_event_t make_event(logic mode, logic [31:0] now, logic [7:0] id,
                                              logic [31:0] arrival, logic [7:0] prio,
                                              logic [31:0] burst);
    return '{mode, now, id, arrival, prio, burst};
  endfunction

  function automatic sched_event_t random_event(logic mode);
    sched_event_t ev;
    clock_now = clock_now + $urandom_range(0, 50);
    ev.mode = mode;
    ev.now = ($urandom_range(0, 9) == 0) ? $urandom : clock_now;
    ev.id = $urandom;
    ev.arrival = ($urandom_range(0, 4) == 0) ? $urandom : clock_now;
    ev.prio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
    ev.burst = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
    return ev;
  endfunction

  initial begin
    int phase;
    int idle_pct;
    int sent;
    int run_len;
    int k;
    logic run_mode;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_ARRIVAL;
    in_now_time <= '0;
    in_new_id <= '0;
    in_new_arrival <= '0;
    in_new_priority <= '0;
    in_new_burst <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(make_event(MODE_COMPLETE, 0, 0, 0, 0, 0), 0);
    issue(make_event(MODE_ARRIVAL, 5, 8'hFF, 32'hFFFF_FFFF, 128, 32'hFFFF_FFFF), 0);
    issue(make_event(MODE_ARRIVAL, 6, 1, 6, 255, 10), 0);
    issue(make_event(MODE_ARRIVAL, 7, 2, 7, 128, 20), 0);
    issue(make_event(MODE_ARRIVAL, 10, 0, 0, 1, 0), 0);
    for (k = 0; k < QUEUE_DEPTH - 3; k++) begin
      issue(make_event(MODE_ARRIVAL, 20 + k, 16 + k, 20 + k, 200, 3 * k + 1), 0);
    end
    issue(make_event(MODE_ARRIVAL, 40, 8'hAA, 40, 0, 5), 0);
    issue(make_event(MODE_ARRIVAL, 41, 8'h55, 41, 255, 5), 0);
    repeat (4) issue(make_event(MODE_COMPLETE, 50, 0, 0, 0, 0), 0);
    clock_now = 100;

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 47 : 29;
      sent = 0;
      run_mode = MODE_ARRIVAL;
      while (sent < RANDOM_PER_PHASE) begin
        run_len = (run_mode == MODE_ARRIVAL) ? $urandom_range(1, 22) : $urandom_range(1, 18);
        for (k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 9) == 0) issue(random_event(~run_mode), idle_pct);
          else issue(random_event(run_mode), idle_pct);
          sent++;
        end
        run_mode = ~run_mode;
      end
    end

    start <= 1'b0;
    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d events: %0d arrivals, %0d completions, deepest queue %0d.",
             sb.results, sb.arrivals, sb.completions, sb.deepest);
    $display("Saw %0d queue-full drops and %0d empty-queue completions; %0d mismatches.",
             sb.overflows, sb.null_runs, sb.errors);
    if (sb.errors == 0 && sb.expected_runs.size() == 0) begin
      $display("[preemptive_priority_scheduler] OK");
    end else begin
      $display("[preemptive_priority_scheduler] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/psch_pkg.sv
sv/psch_queue.sv
sv/psch_minscan.sv
sv/preemptive_priority_scheduler.sv
dv/preemptive_priority_scheduler_tb.sv
